[sv/ubtf_pkg.sv]
// Shared types and constants for the UART bit-tick framer.
package ubtf_pkg;

    localparam int FRAME_W = 12;

    // configuration register indexes
    localparam logic [1:0] REG_WORD_LEN  = 2'd0;
    localparam logic [1:0] REG_STOP_BITS = 2'd1;
    localparam logic [1:0] REG_PARITY    = 2'd2;

    // parity codes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_ODD  = 2'd1;
    localparam logic [1:0] PAR_EVEN = 2'd2;

    localparam logic [3:0] WORD_LEN_RST  = 4'd8;
    localparam logic [1:0] STOP_BITS_RST = 2'd1;
    localparam logic [1:0] PARITY_RST    = PAR_NONE;

    // effective (clamped) line settings
    typedef struct packed {
        logic [3:0] word_len;  // 5..8
        logic [1:0] stop_bits; // 1..2
        logic       par_on;
        logic       par_odd;
    } cfg_t;

    // receiver per-tick result and status
    typedef struct packed {
        logic [7:0] word;
        logic       word_valid;
        logic       in_frame;
    } rx_res_t;

    // transmitter per-tick result and status
    typedef struct packed {
        logic line;
        logic taken;
        logic empty;
    } tx_res_t;

endpackage

[sv/uart_bit_tick_framer.sv]
// Top level of the UART bit-tick framer: config registers, rx/tx units, result register.
//
// Usage
//   Each request on the s_ channel is one baud tick: the sampled receive line
//   (s_rx_bit), clear-to-send (s_cts) and an optional word to send
//   (s_tx_word / s_tx_word_valid). Every tick yields exactly one request on
//   the m_ channel: the transmit line level after the tick, a received word
//   with its valid flag, and whether the offered word was taken into a frame.
//   The result is registered and presented in the cycle after the tick is accepted.
//   Throughput: one tick per cycle unless m_ready stalls; all receiver and transmitter
//   updates are one short pass of logic from state registers to the result register.
//   s_ready is high whenever the result register is empty or being drained,
//   so a stalled receiver holds the result and back-pressures the ticks; no
//   state moves while a tick is not accepted.
//   Configuration (word length, stop bits, parity) is written through the cfg_
//   port, one register per cycle; the user keeps writes to times when no tick is
//   in flight, which the block itself leaves unchecked. Reset (aresetn low,
//   synchronous) restores 8N1, idles the line high, empties the transmitter,
//   sets the receiver waiting for a start bit and marks the result register empty.
module uart_bit_tick_framer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [3:0] cfg_wdata,
    // tick requests
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_rx_bit,
    input  logic       s_cts,
    input  logic [7:0] s_tx_word,
    input  logic       s_tx_word_valid,
    // results
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_line,
    output logic [7:0] m_rx_word,
    output logic       m_rx_word_valid,
    output logic       m_tx_word_taken
);

    // raw configuration registers
    logic [3:0] word_len_reg;
    logic [1:0] stop_bits_reg;
    logic [1:0] parity_reg;

    ubtf_pkg::cfg_t    cfg;
    ubtf_pkg::rx_res_t rx_res;
    ubtf_pkg::tx_res_t tx_res;

    logic       s_fire;
    logic       out_valid_reg;
    logic       tx_line_reg;
    logic [7:0] rx_word_reg;
    logic       rx_word_valid_reg;
    logic       taken_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_len_reg  <= ubtf_pkg::WORD_LEN_RST;
            stop_bits_reg <= ubtf_pkg::STOP_BITS_RST;
            parity_reg    <= ubtf_pkg::PARITY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ubtf_pkg::REG_WORD_LEN:  word_len_reg  <= cfg_wdata;
                ubtf_pkg::REG_STOP_BITS: stop_bits_reg <= cfg_wdata[1:0];
                ubtf_pkg::REG_PARITY:    parity_reg    <= cfg_wdata[1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // clamp out-of-range settings; parity code three means none
    always_comb begin
        if (word_len_reg < 4'd5) begin
            cfg.word_len = 4'd5;
        end else if (word_len_reg > 4'd8) begin
            cfg.word_len = 4'd8;
        end else begin
            cfg.word_len = word_len_reg;
        end
        case (stop_bits_reg)
            2'd0:    cfg.stop_bits = 2'd1;
            2'd3:    cfg.stop_bits = 2'd2;
            default: cfg.stop_bits = stop_bits_reg;
        endcase
        cfg.par_on  = (parity_reg == ubtf_pkg::PAR_ODD) || (parity_reg == ubtf_pkg::PAR_EVEN);
        cfg.par_odd = (parity_reg == ubtf_pkg::PAR_ODD);
    end

    // tick taken when the result slot is free or emptying this cycle
    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    ubtf_rx u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (s_fire),
        .rx_bit  (s_rx_bit),
        .cfg     (cfg),
        .res     (rx_res)
    );

    ubtf_tx u_tx (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tick_en       (s_fire),
        .cts           (s_cts),
        .tx_word       (s_tx_word),
        .tx_word_valid (s_tx_word_valid),
        .cfg           (cfg),
        .res           (tx_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tx_line_reg       <= tx_res.line;
            rx_word_reg       <= rx_res.word;
            rx_word_valid_reg <= rx_res.word_valid;
            taken_reg         <= tx_res.taken;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_tx_line       = tx_line_reg;
    assign m_rx_word       = rx_word_reg;
    assign m_rx_word_valid = rx_word_valid_reg;
    assign m_tx_word_taken = taken_reg;

`ifndef ASSERT_OFF
    // an accepted tick always leaves a result behind it
    a_tick_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted tick produced no result");

    // a freshly loaded frame is never finished on the very next tick
    a_load_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && tx_res.taken |=> !tx_res.empty)
        else $error("transmitter empty right after load");

    // a completed frame returns the receiver to hunting for a start bit
    a_rx_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && rx_res.word_valid |=> !rx_res.in_frame)
        else $error("receiver still in frame after word delivered");

    // the received word is zero whenever no frame completed
    a_rx_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rx_word_valid |-> m_rx_word == 8'd0)
        else $error("stray received word without valid");
`endif

endmodule

[sv/ubtf_rx.sv]
// Receiver: start detection, bit counting and word extraction per baud tick.
module ubtf_rx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                rx_bit,
    input  ubtf_pkg::cfg_t      cfg,
    output ubtf_pkg::rx_res_t   res
);

    logic [ubtf_pkg::FRAME_W-1:0] shift_reg, shift_next;
    logic                         in_frame_reg, in_frame_next;
    logic [3:0]                   count_reg, count_next;

    logic [1:0] tail;
    logic [4:0] frame_bits;
    logic [3:0] count_inc;
    logic [ubtf_pkg::FRAME_W-1:0] shifted;
    logic [7:0] word_mask;

    always_comb begin
        tail       = cfg.stop_bits + {1'b0, cfg.par_on};
        frame_bits = {1'b0, cfg.word_len} + {3'b000, tail};
        shift_next = {shift_reg[ubtf_pkg::FRAME_W-2:0], rx_bit};
        count_inc  = count_reg + 4'd1;
        shifted    = shift_next >> tail;
        word_mask  = 8'hFF >> (4'd8 - cfg.word_len);

        count_next     = count_inc;
        in_frame_next  = in_frame_reg;
        res.word       = 8'd0;
        res.word_valid = 1'b0;
        if (!in_frame_reg) begin
            // falling edge on the line marks a start bit
            if (shift_reg[0] && !rx_bit) begin
                in_frame_next = 1'b1;
                count_next    = 4'd0;
            end
        end else if ({1'b0, count_inc} == frame_bits) begin
            in_frame_next  = 1'b0;
            count_next     = 4'd0;
            res.word       = shifted[7:0] & word_mask;
            res.word_valid = 1'b1;
        end
        res.in_frame = in_frame_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= '0;
            in_frame_reg <= 1'b0;
            count_reg    <= 4'd0;
        end else if (tick_en) begin
            shift_reg    <= shift_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

endmodule

[sv/ubtf_tx.sv]
// Transmitter: frame loading and one-bit-per-tick serialisation while clear to send.
module ubtf_tx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                cts,
    input  logic [7:0]          tx_word,
    input  logic                tx_word_valid,
    input  ubtf_pkg::cfg_t      cfg,
    output ubtf_pkg::tx_res_t   res
);

    logic [ubtf_pkg::FRAME_W-1:0] frame_reg, frame_next;
    logic [3:0]                   len_reg, len_next;
    logic [3:0]                   sent_reg, sent_next;
    logic                         empty_reg, empty_next;
    logic                         line_reg, line_next;

    logic                         load;
    logic [7:0]                   data;
    logic                         par_bit;
    logic [1:0]                   tail;
    logic [ubtf_pkg::FRAME_W-1:0] load_frame;
    logic [1:0]                   stop_ones;
    logic [3:0]                   idx;
    logic [15:0]                  frame_pad;

    always_comb begin
        load      = empty_reg && tx_word_valid;
        data      = tx_word & (8'hFF >> (4'd8 - cfg.word_len));
        par_bit   = (^data) ^ cfg.par_odd;
        tail      = cfg.stop_bits + {1'b0, cfg.par_on};
        stop_ones = (cfg.stop_bits == 2'd2) ? 2'b11 : 2'b01;
        // start bit is the implicit zero at position len-1
        load_frame = ({4'b0000, data} << tail)
                   | ({11'd0, par_bit & cfg.par_on} << cfg.stop_bits)
                   | {10'd0, stop_ones};

        frame_next = frame_reg;
        len_next   = len_reg;
        sent_next  = sent_reg;
        empty_next = empty_reg;
        line_next  = line_reg;
        if (load) begin
            frame_next = load_frame;
            len_next   = 4'd1 + cfg.word_len + {2'b00, tail};
            sent_next  = 4'd0;
            empty_next = 1'b0;
        end

        idx       = len_next - 4'd1 - sent_next;
        frame_pad = {4'b0000, frame_next};
        if (cts && !empty_next) begin
            line_next = frame_pad[idx];
            sent_next = sent_next + 4'd1;
            if (sent_next == len_next) begin
                empty_next = 1'b1;
            end
        end

        res.line  = line_next;
        res.taken = load;
        res.empty = empty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            len_reg   <= 4'd0;
            sent_reg  <= 4'd0;
            empty_reg <= 1'b1;
            line_reg  <= 1'b1;
        end else if (tick_en) begin
            frame_reg <= frame_next;
            len_reg   <= len_next;
            sent_reg  <= sent_next;
            empty_reg <= empty_next;
            line_reg  <= line_next;
        end
    end

endmodule

[bench/uart_bit_tick_framer_test.sv]
// Self-checking testbench for the UART bit-tick framer: directed and random ticks, predicted results.
module uart_bit_tick_framer_test;

    // reserved parity code: the block treats it as no parity
    localparam logic [1:0] PAR_RESERVED = 2'd3;

    // per-tick result as the block should present it
    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_word;
        logic       rx_word_valid;
        logic       tx_word_taken;
    } tick_res_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [3:0] cfg_wdata = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_rx_bit = 1'b1;
    logic       s_cts = 1'b0;
    logic [7:0] s_tx_word = '0;
    logic       s_tx_word_valid = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_tx_line;
    logic [7:0] m_rx_word;
    logic       m_rx_word_valid;
    logic       m_tx_word_taken;

    uart_bit_tick_framer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_bit        (s_rx_bit),
        .s_cts           (s_cts),
        .s_tx_word       (s_tx_word),
        .s_tx_word_valid (s_tx_word_valid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_line       (m_tx_line),
        .m_rx_word       (m_rx_word),
        .m_rx_word_valid (m_rx_word_valid),
        .m_tx_word_taken (m_tx_word_taken)
    );

    always #5 aclk = ~aclk;

    // Idling control, changed per phase of the run
    int send_gap_pct = 26;
    int recv_stall_pct = 62;

    tick_res_t expected_ticks[$];
    int        mismatch_count = 0;
    int        tick_count = 0;

    // Shadow copy of the line settings as last written
    logic [3:0] cfg_word_len;
    logic [1:0] cfg_stop;
    logic [1:0] cfg_parity;

    // Predicted framer state
    logic [11:0] rx_shift_q;
    logic        rx_in_frame_q;
    logic [3:0]  rx_count_q;
    logic [11:0] tx_frame_q;
    logic [3:0]  tx_len_q;
    logic [3:0]  tx_sent_q;
    logic        tx_empty_q;
    logic        line_q;

    // Out-of-range settings clamp to the nearest legal value
    function automatic int eff_word_len();
        if (cfg_word_len < 4'd5) return 5;
        if (cfg_word_len > 4'd8) return 8;
        return int'(cfg_word_len);
    endfunction

    function automatic int eff_stop_bits();
        if (cfg_stop == 2'd0) return 1;
        if (cfg_stop == 2'd3) return 2;
        return int'(cfg_stop);
    endfunction

    function automatic logic parity_enabled();
        return (cfg_parity == ubtf_pkg::PAR_ODD) || (cfg_parity == ubtf_pkg::PAR_EVEN);
    endfunction

    task automatic reset_predictor();
        cfg_word_len  = ubtf_pkg::WORD_LEN_RST;
        cfg_stop      = ubtf_pkg::STOP_BITS_RST;
        cfg_parity    = ubtf_pkg::PARITY_RST;
        rx_shift_q    = '0;
        rx_in_frame_q = 1'b0;
        rx_count_q    = '0;
        tx_frame_q    = '0;
        tx_len_q      = '0;
        tx_sent_q     = '0;
        tx_empty_q    = 1'b1;
        line_q        = 1'b1;
    endtask

    // One baud tick: receiver, then transmitter load, then transmitter send.
    function automatic tick_res_t predict_tick(input logic rx_bit, input logic cts,
                                               input logic [7:0] word, input logic offer);
        tick_res_t   res;
        logic        prev;
        logic        par;
        logic [11:0] frame;
        logic [11:0] shifted;
        int          wl;
        int          sb;
        int          tail;
        int          idx;
        int          i;
        res  = '0;
        wl   = eff_word_len();
        sb   = eff_stop_bits();
        tail = sb + (parity_enabled() ? 1 : 0);

        // receiver: shift every tick, count always, start on a falling edge while idle
        prev       = rx_shift_q[0];
        rx_shift_q = {rx_shift_q[10:0], rx_bit};
        rx_count_q = rx_count_q + 4'd1;
        if (!rx_in_frame_q) begin
            if (prev && !rx_bit) begin
                rx_in_frame_q = 1'b1;
                rx_count_q    = '0;
            end
        end else if (int'(rx_count_q) == wl + tail) begin
            // data sits above the tail bits, first bit received highest
            rx_count_q        = '0;
            rx_in_frame_q     = 1'b0;
            shifted           = rx_shift_q >> tail;
            res.rx_word       = shifted[7:0] & (8'hff >> (8 - wl));
            res.rx_word_valid = 1'b1;
        end

        // transmitter load: start bit is the implicit zero above the frame bits
        if (tx_empty_q && offer) begin
            frame    = '0;
            par      = 1'b0;
            tx_len_q = 4'd1;
            for (i = 0; i < wl; i++) begin
                frame    = {frame[10:0], word[wl-1-i]};
                par      = par ^ word[wl-1-i];
                tx_len_q = tx_len_q + 4'd1;
            end
            if (parity_enabled()) begin
                frame    = {frame[10:0], par ^ (cfg_parity == ubtf_pkg::PAR_ODD)};
                tx_len_q = tx_len_q + 4'd1;
            end
            for (i = 0; i < sb; i++) begin
                frame    = {frame[10:0], 1'b1};
                tx_len_q = tx_len_q + 4'd1;
            end
            tx_frame_q        = frame;
            tx_sent_q         = '0;
            tx_empty_q        = 1'b0;
            res.tx_word_taken = 1'b1;
        end

        // transmitter send: one bit per tick while clear to send
        if (cts && !tx_empty_q) begin
            idx       = int'(tx_len_q) - 1 - int'(tx_sent_q);
            line_q    = tx_frame_q[idx];
            tx_sent_q = tx_sent_q + 4'd1;
            if (tx_sent_q == tx_len_q) tx_empty_q = 1'b1;
        end

        res.tx_line = line_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Send one tick request; inputs move on the falling edge, acceptance is seen on the rising edge.
    task automatic send_tick(input logic rx_bit, input logic cts, input logic [7:0] word,
                             input logic offer);
        int gap;
        gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid         <= 1'b1;
        s_rx_bit        <= rx_bit;
        s_cts           <= cts;
        s_tx_word       <= word;
        s_tx_word_valid <= offer;
        do @(posedge aclk); while (!s_ready);
        expected_ticks.push_back(predict_tick(rx_bit, cts, word, offer));
        tick_count++;
    endtask

    // Tick with a given line level and random transmit side
    task automatic send_line_bit(input logic rx_bit);
        send_tick(rx_bit, $urandom_range(99) < 80, 8'($urandom_range(255)),
                  $urandom_range(99) < 55);
    endtask

    // Well-formed receive frame under the current settings; parity sometimes wrong
    task automatic send_rx_frame(input logic [7:0] word);
        int   wl;
        int   sb;
        int   i;
        logic par;
        wl  = eff_word_len();
        sb  = eff_stop_bits();
        par = (cfg_parity == ubtf_pkg::PAR_ODD);
        repeat ($urandom_range(1, 3)) send_line_bit(1'b1);
        send_line_bit(1'b0);
        for (i = wl - 1; i >= 0; i--) begin
            send_line_bit(word[i]);
            par = par ^ word[i];
        end
        if (parity_enabled())
            send_line_bit(($urandom_range(99) < 25) ? ~par : par);
        repeat (sb) send_line_bit(1'b1);
    endtask

    // Stop sending, wait for every predicted result, then let the bench idle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Only called with no request in flight
    task automatic set_config(input logic [3:0] wl, input logic [1:0] sb,
                              input logic [1:0] par);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= ubtf_pkg::REG_WORD_LEN;
        cfg_wdata <= wl;
        @(negedge aclk);
        cfg_addr  <= ubtf_pkg::REG_STOP_BITS;
        cfg_wdata <= {2'b00, sb};
        @(negedge aclk);
        cfg_addr  <= ubtf_pkg::REG_PARITY;
        cfg_wdata <= {2'b00, par};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_word_len = wl;
        cfg_stop     = sb;
        cfg_parity   = par;
    endtask

    // Receiver stall pattern follows the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each result request is checked against the oldest prediction
    always @(posedge aclk) begin : result_check
        tick_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_ticks.pop_front();
                if (m_tx_line !== want.tx_line)
                    report_mismatch("tx_line", m_tx_line, want.tx_line);
                if (m_rx_word !== want.rx_word)
                    report_mismatch("rx_word", m_rx_word, want.rx_word);
                if (m_rx_word_valid !== want.rx_word_valid)
                    report_mismatch("rx_word_valid", m_rx_word_valid, want.rx_word_valid);
                if (m_tx_word_taken !== want.tx_word_taken)
                    report_mismatch("tx_word_taken", m_tx_word_taken, want.tx_word_taken);
            end
        end
    end

    // Line idle high, nothing offered: tx holds high, idle receiver keeps counting
    task automatic test_idle_line();
        send_tick(1'b1, 1'b0, 8'h00, 1'b0);
        send_tick(1'b1, 1'b1, 8'hff, 1'b0);
        send_tick(1'b1, 1'b1, 8'h00, 1'b0);
    endtask

    // Word taken with cts low; a second offer while busy is refused
    task automatic test_offer_while_busy();
        send_tick(1'b1, 1'b0, 8'hff, 1'b1);
        send_tick(1'b1, 1'b0, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
    endtask

    // Word length 0, stop bits 0 and the reserved parity code all clamp to 5N1
    task automatic test_clamped_config();
        wait_idle();
        set_config(4'd0, 2'd0, PAR_RESERVED);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b0, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
    endtask

    // Settings shrink mid-frame: receiver counts on against the new frame length, tx frame keeps its framing
    task automatic test_mid_frame_config();
        wait_idle();
        set_config(4'd15, 2'd3, ubtf_pkg::PAR_ODD);
        send_tick(1'b1, 1'b1, 8'h5a, 1'b1);
        send_tick(1'b0, 1'b1, 8'hff, 1'b1);
        send_tick(1'b1, 1'b1, 8'hff, 1'b1);
        send_tick(1'b1, 1'b0, 8'hff, 1'b1);
        wait_idle();
        set_config(4'd5, 2'd1, ubtf_pkg::PAR_EVEN);
        send_tick(1'b0, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
        send_tick(1'b1, 1'b1, 8'h00, 1'b1);
    endtask

    // Random frames and noise over three idling phases and nine line settings
    task automatic test_random_traffic();
        int phase;
        int seg;
        int seg_end;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 26;
                    recv_stall_pct = 62;
                end
                1: begin
                    send_gap_pct   = 62;
                    recv_stall_pct = 26;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (seg = 0; seg < 3; seg++) begin
                // sender holds off here until every result is back
                wait_idle();
                case (phase * 3 + seg)
                    0: set_config(4'd5, 2'd1, ubtf_pkg::PAR_NONE);
                    1: set_config(4'd8, 2'd2, ubtf_pkg::PAR_EVEN);
                    2: set_config(4'd6, 2'd1, ubtf_pkg::PAR_ODD);
                    3: set_config(4'd7, 2'd2, ubtf_pkg::PAR_NONE);
                    4: set_config(4'd5, 2'd2, ubtf_pkg::PAR_ODD);
                    5: set_config(4'd8, 2'd1, ubtf_pkg::PAR_EVEN);
                    6: set_config(4'($urandom_range(15)), 2'($urandom_range(3)),
                                  2'($urandom_range(3)));
                    7: set_config(4'd8, 2'd2, ubtf_pkg::PAR_ODD);
                    default: set_config(4'd5, 2'd1, ubtf_pkg::PAR_EVEN);
                endcase
                seg_end = tick_count + 38;
                while (tick_count < seg_end) begin
                    if ($urandom_range(99) < 85)
                        send_rx_frame(8'($urandom_range(255)));
                    else
                        repeat ($urandom_range(1, 4)) send_line_bit(1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_line();
        test_offer_while_busy();
        test_clamped_config();
        test_mid_frame_config();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
